// ===== rtl/cpd_pkg.sv =====
// shared types, constants and helper functions for the command packet deframer
package cpd_pkg;

    localparam int HEADER_BYTES_DEF = 4;

    localparam logic [7:0] FLAG_DRIVE    = 8'b0000_0001;
    localparam logic [7:0] FLAG_RESPONSE = 8'b0000_0010;
    localparam logic [7:0] FLAG_SLEEP    = 8'b0000_0100;
    localparam logic [7:0] FLAG_ACK      = 8'b0000_1000;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_BODY   = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    localparam logic [1:0] CMD_DRIVE    = 2'd0;
    localparam logic [1:0] CMD_RESPONSE = 2'd1;
    localparam logic [1:0] CMD_SLEEP    = 2'd2;

    typedef struct packed {
        logic [7:0]  byte_position;
        logic [15:0] count_latch;
        logic [7:0]  flag_latch;
        logic [7:0]  length_latch;
        logic [7:0]  ones_total;
    } deframe_state_t;

    typedef struct packed {
        logic [1:0]  item_kind;
        logic [7:0]  body_byte;
        logic [7:0]  body_index;
        logic [15:0] packet_count;
        logic [1:0]  command;
        logic        ack_flag;
        logic [7:0]  frame_length;
        logic        check_ok;
        logic        length_error;
    } deframe_result_t;

    function automatic logic [3:0] ones_in(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + 4'(v[i]);
        end
        return n;
    endfunction

    function automatic logic [1:0] decode_command(input logic [7:0] f);
        logic [1:0] c;
        if ((f & FLAG_DRIVE) != 8'd0)
        begin
            c = CMD_DRIVE;
        end
        else if ((f & FLAG_RESPONSE) != 8'd0)
        begin
            c = CMD_RESPONSE;
        end
        else if ((f & FLAG_SLEEP) != 8'd0)
        begin
            c = CMD_SLEEP;
        end
        else
        begin
            c = CMD_DRIVE;
        end
        return c;
    endfunction

endpackage

// ===== rtl/cpd_if.sv =====
// stream interfaces for received bytes and deframed result items
interface cpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       restart;

    modport source (output valid, output rx_byte, output restart, input ready);
    modport sink (input valid, input rx_byte, input restart, output ready);
endinterface

interface cpd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  item_kind;
    logic [7:0]  body_byte;
    logic [7:0]  body_index;
    logic [15:0] packet_count;
    logic [1:0]  command;
    logic        ack_flag;
    logic [7:0]  frame_length;
    logic        check_ok;
    logic        length_error;

    modport source (
        output valid, output item_kind, output body_byte, output body_index,
        output packet_count, output command, output ack_flag, output frame_length,
        output check_ok, output length_error, input ready
    );
    modport sink (
        input valid, input item_kind, input body_byte, input body_index,
        input packet_count, input command, input ack_flag, input frame_length,
        input check_ok, input length_error, output ready
    );
endinterface

// ===== rtl/cpd_step.sv =====
// next-state and result logic for one received byte
module cpd_step
    import cpd_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
)
(
    input  deframe_state_t  cur_state,
    input  logic [7:0]      rx_byte,
    input  logic            restart,
    output deframe_state_t  next_state,
    output deframe_result_t result
);

    localparam logic [7:0] LAST_HEADER = 8'(HEADER_BYTES - 1);
    localparam logic [7:0] MIN_LENGTH  = 8'(HEADER_BYTES + 1);
    localparam logic [7:0] HDR_LEN     = 8'(HEADER_BYTES);

    deframe_state_t st;
    deframe_state_t upd;
    logic [7:0]     ones_sum;

    always_comb
    begin
        st         = restart ? '0 : cur_state;
        ones_sum   = st.ones_total + 8'(ones_in(rx_byte));
        upd        = st;
        result     = '0;
        next_state = '0;

        if (st.byte_position < HDR_LEN)
        begin
            case (st.byte_position)
                8'd0:    upd.count_latch[7:0]  = rx_byte;
                8'd1:    upd.count_latch[15:8] = rx_byte;
                8'd2:    upd.flag_latch        = rx_byte;
                default: upd.length_latch      = rx_byte;
            endcase
            upd.ones_total = ones_sum;
            if (st.byte_position == LAST_HEADER && rx_byte < MIN_LENGTH)
            begin
                // short length closes the frame at once
                result.item_kind    = KIND_END;
                result.packet_count = upd.count_latch;
                result.command      = decode_command(upd.flag_latch);
                result.ack_flag     = (upd.flag_latch & FLAG_ACK) != 8'd0;
                result.frame_length = rx_byte;
                result.length_error = 1'b1;
            end
            else
            begin
                next_state               = upd;
                next_state.byte_position = st.byte_position + 8'd1;
                result.item_kind         = KIND_HEADER;
            end
        end
        else if (({1'b0, st.byte_position} + 9'd1) >= {1'b0, st.length_latch})
        begin
            // check byte
            result.item_kind    = KIND_END;
            result.packet_count = st.count_latch;
            result.command      = decode_command(st.flag_latch);
            result.ack_flag     = (st.flag_latch & FLAG_ACK) != 8'd0;
            result.frame_length = st.length_latch;
            result.check_ok     = st.ones_total == rx_byte;
        end
        else
        begin
            result.item_kind         = KIND_BODY;
            result.body_byte         = rx_byte;
            result.body_index        = st.byte_position - HDR_LEN;
            next_state               = st;
            next_state.ones_total    = ones_sum;
            next_state.byte_position = st.byte_position + 8'd1;
        end
    end

endmodule

// ===== rtl/command_packet_deframer.sv =====
// command packet deframer top level: packet state and registered result stage
// the result item of an accepted byte is registered and valid in the cycle after it is accepted
// throughput: one byte per cycle while the output is not stalled
// input ready drops only while a result waits and the output is stalled
// reset clears the packet state and the output valid; the first byte after
// reset is taken as the first count byte of a packet
module command_packet_deframer
    import cpd_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    cpd_in_if.sink        bytes_in,
    cpd_out_if.source     items_out
);

    deframe_state_t  state_reg;
    deframe_state_t  state_next;
    deframe_result_t result_reg;
    deframe_result_t result_next;
    logic            out_valid_reg;
    logic            in_accept;

    assign bytes_in.ready = !out_valid_reg || items_out.ready;
    assign in_accept      = bytes_in.valid && bytes_in.ready;

    cpd_step #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_step (
        .cur_state  (state_reg),
        .rx_byte    (bytes_in.rx_byte),
        .restart    (bytes_in.restart),
        .next_state (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (items_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            result_reg <= result_next;
        end
    end

    assign items_out.valid        = out_valid_reg;
    assign items_out.item_kind    = result_reg.item_kind;
    assign items_out.body_byte    = result_reg.body_byte;
    assign items_out.body_index   = result_reg.body_index;
    assign items_out.packet_count = result_reg.packet_count;
    assign items_out.command      = result_reg.command;
    assign items_out.ack_flag     = result_reg.ack_flag;
    assign items_out.frame_length = result_reg.frame_length;
    assign items_out.check_ok     = result_reg.check_ok;
    assign items_out.length_error = result_reg.length_error;

endmodule

// ===== rtl/cpd_checker.sv =====
// port-level checker for the command packet deframer and its bind
module cpd_checker
    import cpd_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  item_kind,
    input logic [7:0]  body_byte,
    input logic [7:0]  body_index,
    input logic [7:0]  frame_length,
    input logic        check_ok,
    input logic        length_error
);

    localparam logic [7:0] MIN_LENGTH = 8'(HEADER_BYTES + 1);

    // every accepted transaction yields a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted byte produced no result");

    // stalled result stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(item_kind) && $stable(body_byte))
        else $error("stalled result changed");

    // body fields are zero outside body items
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && item_kind != KIND_BODY |-> body_byte == 8'd0 && body_index == 8'd0)
        else $error("body fields set on a non-body item");

    // a length error only comes with a short length and never with a good check
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && length_error |->
            item_kind == KIND_END && frame_length < MIN_LENGTH && !check_ok)
        else $error("inconsistent length error report");

endmodule

bind command_packet_deframer cpd_checker #(
    .HEADER_BYTES (HEADER_BYTES)
) u_cpd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (bytes_in.valid),
    .in_ready     (bytes_in.ready),
    .out_valid    (items_out.valid),
    .out_ready    (items_out.ready),
    .item_kind    (items_out.item_kind),
    .body_byte    (items_out.body_byte),
    .body_index   (items_out.body_index),
    .frame_length (items_out.frame_length),
    .check_ok     (items_out.check_ok),
    .length_error (items_out.length_error)
);

// ===== bench/deframe_checker.sv =====
// checker for the command packet deframer: predicts result transactions and compares them
module deframe_checker
    import cpd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    cpd_in_if     bytes_mon,
    cpd_out_if    items_mon,
    output int    mismatches,
    output int    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]  position;
    logic [15:0] count_acc;
    logic [7:0]  flags_held;
    logic [7:0]  length_held;
    logic [7:0]  ones_acc;

    deframe_result_t expected_items[$];

    function automatic logic [1:0] command_of(input logic [7:0] f);
        if ((f & FLAG_DRIVE) != 8'd0)
            return CMD_DRIVE;
        if ((f & FLAG_RESPONSE) != 8'd0)
            return CMD_RESPONSE;
        if ((f & FLAG_SLEEP) != 8'd0)
            return CMD_SLEEP;
        return CMD_DRIVE;
    endfunction

    task automatic drop_packet();
        position    = 8'd0;
        count_acc   = 16'd0;
        flags_held  = 8'd0;
        length_held = 8'd0;
        ones_acc    = 8'd0;
    endtask

    task automatic close_frame(input logic ok, input logic short_len,
                               output deframe_result_t r);
        r              = '0;
        r.item_kind    = KIND_END;
        r.packet_count = count_acc;
        r.command      = command_of(flags_held);
        r.ack_flag     = (flags_held & FLAG_ACK) != 8'd0;
        r.frame_length = length_held;
        r.check_ok     = ok;
        r.length_error = short_len;
        drop_packet();
    endtask

    task automatic deframe_predict(input logic [7:0] b, input logic rs,
                                   output deframe_result_t r);
        r = '0;
        if (rs)
            drop_packet();
        if (position < HEADER_BYTES_DEF)
        begin
            case (position)
                8'd0: count_acc[7:0] = b;
                8'd1: count_acc[15:8] = b;
                8'd2: flags_held = b;
                default: length_held = b;
            endcase
            ones_acc = ones_acc + 8'($countones(b));
            if (position == HEADER_BYTES_DEF - 1 && length_held < HEADER_BYTES_DEF + 1)
            begin
                close_frame(1'b0, 1'b1, r);
            end
            else
            begin
                r.item_kind = KIND_HEADER;
                position    = position + 8'd1;
            end
        end
        else if (9'(position) + 9'd1 >= 9'(length_held))
        begin
            close_frame(ones_acc == b, 1'b0, r);
        end
        else
        begin
            r.item_kind  = KIND_BODY;
            r.body_byte  = b;
            r.body_index = position - 8'(HEADER_BYTES_DEF);
            ones_acc     = ones_acc + 8'($countones(b));
            position     = position + 8'd1;
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        deframe_result_t want;
        if (!rst_n)
        begin
            drop_packet();
            expected_items.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (items_mon.valid && items_mon.ready)
            begin
                if (expected_items.size() == 0)
                begin
                    $error("result transaction with nothing expected");
                    mismatches++;
                end
                else
                begin
                    want = expected_items.pop_front();
                    check_field("item_kind", want.item_kind, items_mon.item_kind);
                    check_field("body_byte", want.body_byte, items_mon.body_byte);
                    check_field("body_index", want.body_index, items_mon.body_index);
                    check_field("packet_count", want.packet_count, items_mon.packet_count);
                    check_field("command", want.command, items_mon.command);
                    check_field("ack_flag", want.ack_flag, items_mon.ack_flag);
                    check_field("frame_length", want.frame_length, items_mon.frame_length);
                    check_field("check_ok", want.check_ok, items_mon.check_ok);
                    check_field("length_error", want.length_error, items_mon.length_error);
                end
            end
            if (bytes_mon.valid && bytes_mon.ready)
            begin
                deframe_predict(bytes_mon.rx_byte, bytes_mon.restart, want);
                expected_items.push_back(want);
            end
            outstanding = expected_items.size();
        end
    end

endmodule

// ===== bench/testbench.sv =====
// top of the deframer bench: clock, reset, byte stimulus, output stalls and verdict
module testbench;
    import cpd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   sent_items = 0;
    int   src_idle_pct;
    int   sink_stall_pct;
    logic hold_go;
    logic holding = 1'b0;

    cpd_in_if  bytes_if ();
    cpd_out_if items_if ();

    command_packet_deframer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .bytes_in  (bytes_if),
        .items_out (items_if)
    );

    deframe_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .bytes_mon   (bytes_if),
        .items_mon   (items_if),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // long output stall so the deframer backs up onto its input
    initial
    begin
        @(posedge hold_go);
        @(posedge clk);
        holding = 1'b1;
        repeat (300) @(posedge clk);
        holding = 1'b0;
    end

    initial
    begin
        items_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            items_if.ready <= !holding && ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic rs);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            bytes_if.valid <= 1'b0;
            @(negedge clk);
        end
        bytes_if.valid   <= 1'b1;
        bytes_if.rx_byte <= b;
        bytes_if.restart <= rs;
        @(posedge clk);
        while (!bytes_if.ready)
            @(posedge clk);
        @(negedge clk);
        sent_items++;
    endtask

    task automatic send_frame(input logic [15:0] cnt, input logic [7:0] flags,
                              input logic [7:0] len, input bit bad_check,
                              input logic rs, input int cut);
        logic [7:0] frame[$];
        logic [7:0] ones;
        frame = {cnt[7:0], cnt[15:8], flags, len};
        if (len >= 8'(HEADER_BYTES_DEF + 1))
        begin
            for (int i = 0; i < int'(len) - HEADER_BYTES_DEF - 1; i++)
                frame.push_back(8'($urandom));
            ones = 8'd0;
            foreach (frame[i])
                ones = ones + 8'($countones(frame[i]));
            frame.push_back(bad_check ? ones ^ 8'($urandom_range(1, 255)) : ones);
        end
        if (cut > 0 && cut < frame.size())
            frame = frame[0:cut-1];
        foreach (frame[i])
            send_byte(frame[i], (i == 0) ? rs : 1'b0);
    endtask

    task automatic random_traffic(input int amount);
        int         stop_at;
        int         pick;
        int         r;
        logic [7:0] len;
        logic [7:0] flags;
        bit         resync;
        stop_at = sent_items + amount;
        resync  = 1'b1;
        while (sent_items < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                // stray bytes, stream out of step afterwards
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom), 1'($urandom_range(0, 7) == 0));
                resync = 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 6)
                    len = 8'($urandom_range(0, HEADER_BYTES_DEF));
                else if (r < 8)
                    len = $urandom_range(0, 1) ? 8'd255 : 8'($urandom_range(200, 254));
                else
                    len = 8'($urandom_range(HEADER_BYTES_DEF + 1, 24));
                flags = 8'($urandom) & ~8'((1 << $urandom_range(0, 3)) - 1);
                send_frame(16'($urandom), flags, len, $urandom_range(0, 3) == 0,
                           resync || ($urandom_range(0, 4) == 0),
                           (pick < 20) ? $urandom_range(1, 7) : 0);
                resync = (pick < 20);
            end
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        bytes_if.valid   = 1'b0;
        bytes_if.rx_byte = 8'd0;
        bytes_if.restart = 1'b0;
        src_idle_pct     = 0;
        sink_stall_pct   = 0;
        hold_go          = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // minimal length with count and flags at their top values
        send_frame(16'hFFFF, 8'hFF, 8'd5, 1'b0, 1'b0, 0);
        // short lengths end the frame on the length byte
        send_frame(16'h0000, FLAG_RESPONSE, 8'd0, 1'b0, 1'b0, 0);
        send_frame(16'h00FF, FLAG_SLEEP, 8'd4, 1'b0, 1'b0, 0);
        // ack with no command bit falls back to drive, wrong check byte
        send_frame(16'h8000, FLAG_ACK, 8'd6, 1'b1, 1'b0, 0);
        // restart in the middle of a packet
        send_frame(16'h1234, FLAG_RESPONSE, 8'd9, 1'b0, 1'b0, 1);
        send_frame(16'h0001, 8'h00, 8'd5, 1'b0, 1'b1, 0);

        random_traffic(170);
        hold_go = 1'b1;
        random_traffic(100);
        src_idle_pct = 60;
        random_traffic(140);
        src_idle_pct   = 0;
        sink_stall_pct = 60;
        random_traffic(140);
        src_idle_pct   = 30;
        sink_stall_pct = 30;
        random_traffic(150);

        bytes_if.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/cpd_pkg.sv
rtl/cpd_if.sv
rtl/cpd_step.sv
rtl/command_packet_deframer.sv
rtl/cpd_checker.sv
bench/deframe_checker.sv
bench/testbench.sv
